[rtl/touchpad_report_decoder_macros.svh]
// ----------------------------------------------------------------------------
// Touchpad report decoder assertion macros
// Clocked, reset-gated assertion wrappers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef TOUCHPAD_REPORT_DECODER_MACROS_SVH
`define TOUCHPAD_REPORT_DECODER_MACROS_SVH

// Same-cycle implication on clk, off while rst_n is low.
`define TPRD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication on clk, off while rst_n is low.
`define TPRD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/tprd_pkg.sv]
// ----------------------------------------------------------------------------
// Touchpad report decoder package
// Shared types, byte constants and the packet header test.
// ----------------------------------------------------------------------------
package tprd_pkg;

    localparam logic [7:0] HDR_MASK_A    = 8'hc8;
    localparam logic [7:0] HDR_VAL_A     = 8'h08;
    localparam logic [7:0] HDR_MASK_B    = 8'hf8;
    localparam logic [7:0] BYTE_ALL_ONES = 8'hff;

    // packet type bits, byte 0 bits 5:4
    localparam logic [1:0] TYPE_DROP      = 2'd1;
    localparam logic [1:0] TYPE_NO_SECOND = 2'd2;

    localparam logic [2:0] PKT_LAST_POS  = 3'd7;
    localparam logic [1:0] SLOT_LAST     = 2'd3;
    localparam logic [3:0] FINGERS_LIMIT = 4'd2;

    typedef logic [15:0][7:0] report_bytes_t;
    typedef logic [3:0][11:0] coord_array_t;

    typedef struct packed {
        logic        valid;
        logic [11:0] x;
        logic [11:0] y;
    } finger_t;

    typedef struct packed {
        finger_t [3:0] fingers;
        logic          left;
        logic          right;
    } report_t;

    function automatic logic header_ok(input logic [7:0] b);
        header_ok = ((b & HDR_MASK_A) == HDR_VAL_A) || ((b & HDR_MASK_B) == HDR_MASK_B);
    endfunction

endpackage

[rtl/tprd_report_decode.sv]
// ----------------------------------------------------------------------------
// Touchpad report field decode
// Splits a 16-byte report into four finger slots and the drop decision.
// ----------------------------------------------------------------------------
module tprd_report_decode (
    input  tprd_pkg::report_bytes_t report_bytes,
    input  tprd_pkg::coord_array_t  held_x,
    input  tprd_pkg::coord_array_t  held_y,
    output logic                    keep,
    output tprd_pkg::report_t       rpt
);
    import tprd_pkg::*;

    logic hdr_all_ones;

    always_comb
    begin
        hdr_all_ones = (report_bytes[0] == BYTE_ALL_ONES) && (report_bytes[1] == BYTE_ALL_ONES)
                    && (report_bytes[2] == BYTE_ALL_ONES) && (report_bytes[3] == BYTE_ALL_ONES);
        keep = !hdr_all_ones && (report_bytes[0][5:4] != TYPE_DROP);
        rpt.left  = report_bytes[0][0];
        rpt.right = report_bytes[0][1];
        for (int i = 0; i < 4; i++)
        begin
            // slot i occupies bytes 4i+1 .. 4i+3; all ones means no touch
            rpt.fingers[i].valid = !((report_bytes[4*i+1] == BYTE_ALL_ONES)
                                  && (report_bytes[4*i+2] == BYTE_ALL_ONES)
                                  && (report_bytes[4*i+3] == BYTE_ALL_ONES));
            if (rpt.fingers[i].valid)
            begin
                rpt.fingers[i].x = {report_bytes[4*i+1], report_bytes[4*i+3][7:4]};
                rpt.fingers[i].y = {report_bytes[4*i+2], report_bytes[4*i+3][3:0]};
            end
            else
            begin
                rpt.fingers[i].x = held_x[i];
                rpt.fingers[i].y = held_y[i];
            end
        end
    end

endmodule

[rtl/touchpad_report_decoder.sv]
// ----------------------------------------------------------------------------
// Touchpad report decoder
// Frames the touchpad byte stream into reports and emits finger results.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one beat per received byte, with
//   resync=1 dropping any partial packet. Bytes before a valid header are
//   discarded; eight bytes make a packet, one or two packets a report.
//   Output channel (out_valid/out_ready): each kept report gives four beats,
//   finger slots 0..3, last_of_report set on slot 3.
//   Latency: the first beat of a report is offered the cycle after the byte
//   that completes it is accepted; the beats go one per cycle unless stalled.
//   Throughput: one byte per cycle. Any beat, resync included, is held off
//   only when the packet is one byte short of complete while the previous
//   report still has beats pending; the single report buffer sets that limit.
//   While the receiver stalls, the current beat holds and non-completing
//   bytes are still taken.
//   Reset clears framing, the second-half flag, held coordinates and the
//   output buffer; stored report bytes are not cleared.
// ----------------------------------------------------------------------------
`include "touchpad_report_decoder_macros.svh"

module touchpad_report_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    input  logic        resync,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  finger_index,
    output logic        finger_valid,
    output logic [11:0] pos_x,
    output logic [11:0] pos_y,
    output logic        left_button,
    output logic        right_button,
    output logic        last_of_report
);
    import tprd_pkg::*;

    // framing state
    logic [2:0]    byte_pos_reg;
    logic          awaiting_reg;
    report_bytes_t store_reg;

    // held coordinates per slot
    coord_array_t  held_x_reg;
    coord_array_t  held_y_reg;

    // report buffer feeding the output beats
    report_t       rpt_reg;
    logic          rpt_valid_reg;
    logic [1:0]    slot_reg;

    logic          in_fire;
    logic          out_fire;
    logic          last_fire;
    logic          byte_used;
    logic          pkt_done;
    logic [3:0]    wr_addr;
    report_bytes_t eff_bytes;
    logic [3:0]    finger_cnt;
    logic          go_second;
    logic          keep;
    logic          emit;
    report_t       rpt_next;

    logic [2:0]    byte_pos_next;
    logic          awaiting_next;

    assign out_fire  = out_valid && out_ready;
    assign last_fire = out_fire && (slot_reg == SLOT_LAST);

    // Only a packet-completing byte needs the report buffer.
    assign in_ready = !rpt_valid_reg || (byte_pos_reg != PKT_LAST_POS) || last_fire;
    assign in_fire  = in_valid && in_ready;

    // header test only at the start of a packet
    assign byte_used = in_fire && !resync && ((byte_pos_reg != 3'd0) || header_ok(rx_byte));
    assign pkt_done  = byte_used && (byte_pos_reg == PKT_LAST_POS);
    assign wr_addr   = {awaiting_reg, byte_pos_reg};

    // Report as it stands after this byte; a one-packet report reads the
    // second half as all ones.
    always_comb
    begin
        eff_bytes          = store_reg;
        eff_bytes[wr_addr] = rx_byte;
        if (!awaiting_reg)
        begin
            for (int k = 8; k < 16; k++)
            begin
                eff_bytes[k] = BYTE_ALL_ONES;
            end
        end
    end

    // finger count from byte 4: bits 1:0 plus bits 5:4 weighted by four
    assign finger_cnt = {2'b00, eff_bytes[4][1:0]} + {eff_bytes[4][5:4], 2'b00};

    assign go_second = !awaiting_reg && (finger_cnt > FINGERS_LIMIT)
                    && (eff_bytes[0] != BYTE_ALL_ONES) && (eff_bytes[1] != BYTE_ALL_ONES)
                    && (eff_bytes[2] != BYTE_ALL_ONES) && (eff_bytes[3] != BYTE_ALL_ONES)
                    && (eff_bytes[0][5:4] != TYPE_NO_SECOND);

    tprd_report_decode u_decode (
        .report_bytes (eff_bytes),
        .held_x       (held_x_reg),
        .held_y       (held_y_reg),
        .keep         (keep),
        .rpt          (rpt_next)
    );

    assign emit = pkt_done && !go_second && keep;

    always_comb
    begin
        byte_pos_next = byte_pos_reg;
        awaiting_next = awaiting_reg;
        if (in_fire && resync)
        begin
            byte_pos_next = 3'd0;
        end
        else if (byte_used)
        begin
            byte_pos_next = byte_pos_reg + 3'd1;
        end
        if (pkt_done)
        begin
            awaiting_next = go_second;
        end
    end

    // report bytes: payload, no reset
    always_ff @(posedge clk)
    begin
        if (byte_used)
        begin
            store_reg[wr_addr] <= rx_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_pos_reg  <= 3'd0;
            awaiting_reg  <= 1'b0;
            held_x_reg    <= '0;
            held_y_reg    <= '0;
            rpt_valid_reg <= 1'b0;
            slot_reg      <= 2'd0;
        end
        else
        begin
            byte_pos_reg <= byte_pos_next;
            awaiting_reg <= awaiting_next;
            if (emit)
            begin
                for (int i = 0; i < 4; i++)
                begin
                    held_x_reg[i] <= rpt_next.fingers[i].x;
                    held_y_reg[i] <= rpt_next.fingers[i].y;
                end
            end
            if (emit)
            begin
                rpt_valid_reg <= 1'b1;
            end
            else if (last_fire)
            begin
                rpt_valid_reg <= 1'b0;
            end
            if (out_fire)
            begin
                slot_reg <= slot_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            rpt_reg <= rpt_next;
        end
    end

    // output beats walk the buffered slots
    assign out_valid      = rpt_valid_reg;
    assign finger_index   = slot_reg;
    assign finger_valid   = rpt_reg.fingers[slot_reg].valid;
    assign pos_x          = rpt_reg.fingers[slot_reg].x;
    assign pos_y          = rpt_reg.fingers[slot_reg].y;
    assign left_button    = rpt_reg.left;
    assign right_button   = rpt_reg.right;
    assign last_of_report = (slot_reg == SLOT_LAST);

    // a completing byte never overruns a report still being sent
    `TPRD_ASSERT_NOW(a_no_overrun, pkt_done, !rpt_valid_reg || last_fire, "report buffer overrun")
    // slot counter only moves while a report is pending
    `TPRD_ASSERT_NOW(a_slot_idle, !rpt_valid_reg, slot_reg == 2'd0, "slot moved without report")
    // a kept report is offered on the next cycle starting at slot 0
    `TPRD_ASSERT_NEXT(a_emit_start, emit, out_valid && (finger_index == 2'd0),
        "report not offered after completion")

endmodule
